// ----- src/scc_pkg.sv -----
// ---------------------------------------------------------------------------
// scc_pkg
// Shared types and constants for the SCC counter: widths, FSM states,
// controller command and datapath status groups.
// ---------------------------------------------------------------------------
`default_nettype none

package scc_pkg;

	localparam int EDGE_NODE_W = 8;   // node field of a stored edge
	localparam int NODE_W      = 9;   // node number inside the search
	localparam int LIVE_W      = 10;  // live node count / scan index
	localparam int COUNT_W     = 9;   // node_count register and result
	localparam int APB_AW      = 3;
	localparam int APB_DW      = 32;

	// register index (paddr[2])
	localparam logic REG_NODE_COUNT = 1'b0;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN1,
		ST_SCAN1D,
		ST_FETCH,
		ST_CHECK,
		ST_VCHK,
		ST_POPRD,
		ST_SCAN2,
		ST_SCAN2D,
		ST_SCAN2V,
		ST_DONE
	} state_t;

	// source of the visited-mark lookup
	typedef enum logic [1:0] {
		VS_SCAN,
		VS_EDGE,
		VS_FIN
	} vis_src_t;

	typedef struct packed {
		logic     in_ready;
		logic     load_edge;
		logic     start_run;
		logic     clr_step;
		logic     step_i;
		logic     rd_vis;
		logic     start_search;
		logic     rd_edge;
		logic     adv_e;
		logic     push;
		logic     pop;
		logic     load_top;
		logic     start_pass2;
		logic     rd_finish;
		logic     step_k;
		logic     inc_count;
		logic     emit;
		vis_src_t vis_src;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic i_end;
		logic e_end;
		logic match;
		logic seen;
		logic sp_one;
		logic k_zero;
		logic pass2;
	} sts_t;

endpackage

`default_nettype wire

// ----- src/scc_if.sv -----
// ---------------------------------------------------------------------------
// scc_if
// Valid/ready channels of the SCC counter: item beats in, result beats out.
// ---------------------------------------------------------------------------
`default_nettype none

interface scc_item_if;
	logic       valid;
	logic       ready;
	logic       func;
	logic [7:0] src_node;
	logic [7:0] dst_node;

	modport source(output valid, func, src_node, dst_node, input ready);
	modport sink(input valid, func, src_node, dst_node, output ready);
endinterface

interface scc_result_if;
	logic       valid;
	logic       ready;
	logic [8:0] component_count;
	logic       edges_dropped;

	modport source(output valid, component_count, edges_dropped, input ready);
	modport sink(input valid, component_count, edges_dropped, output ready);
endinterface

`default_nettype wire

// ----- src/scc_ctrl.sv -----
// ---------------------------------------------------------------------------
// scc_ctrl
// Sequencer for edge loading and the two Kosaraju search passes.
// ---------------------------------------------------------------------------
`default_nettype none

module scc_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 item_valid,
	input  wire                 item_func,
	input  wire                 out_busy,
	input  scc_pkg::sts_t       sts,
	output scc_pkg::cmd_t       cmd
);

	scc_pkg::state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= scc_pkg::ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			scc_pkg::ST_CLEAR: begin
				if (sts.clr_last) state_nxt = scc_pkg::ST_IDLE;
			end
			scc_pkg::ST_IDLE: begin
				if (item_valid && item_func) state_nxt = scc_pkg::ST_SCAN1;
			end
			scc_pkg::ST_SCAN1: begin
				if (sts.i_end) state_nxt = scc_pkg::ST_SCAN2;
				else state_nxt = scc_pkg::ST_SCAN1D;
			end
			scc_pkg::ST_SCAN1D: begin
				if (!sts.seen) state_nxt = scc_pkg::ST_FETCH;
				else state_nxt = scc_pkg::ST_SCAN1;
			end
			scc_pkg::ST_FETCH: begin
				if (!sts.e_end) state_nxt = scc_pkg::ST_CHECK;
				else if (!sts.sp_one) state_nxt = scc_pkg::ST_POPRD;
				else if (sts.pass2) state_nxt = scc_pkg::ST_SCAN2;
				else state_nxt = scc_pkg::ST_SCAN1;
			end
			scc_pkg::ST_CHECK: begin
				if (sts.match) state_nxt = scc_pkg::ST_VCHK;
				else state_nxt = scc_pkg::ST_FETCH;
			end
			scc_pkg::ST_VCHK:   state_nxt = scc_pkg::ST_FETCH;
			scc_pkg::ST_POPRD:  state_nxt = scc_pkg::ST_FETCH;
			scc_pkg::ST_SCAN2: begin
				if (sts.k_zero) state_nxt = scc_pkg::ST_DONE;
				else state_nxt = scc_pkg::ST_SCAN2D;
			end
			scc_pkg::ST_SCAN2D: state_nxt = scc_pkg::ST_SCAN2V;
			scc_pkg::ST_SCAN2V: begin
				if (!sts.seen) state_nxt = scc_pkg::ST_FETCH;
				else state_nxt = scc_pkg::ST_SCAN2;
			end
			scc_pkg::ST_DONE: begin
				if (!out_busy) state_nxt = scc_pkg::ST_IDLE;
			end
			default: state_nxt = scc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.vis_src = scc_pkg::VS_SCAN;
		unique case (state_q)
			scc_pkg::ST_CLEAR: cmd.clr_step = 1'b1;
			scc_pkg::ST_IDLE: begin
				cmd.in_ready  = 1'b1;
				cmd.load_edge = item_valid && !item_func;
				cmd.start_run = item_valid && item_func;
			end
			scc_pkg::ST_SCAN1: begin
				if (sts.i_end) begin
					cmd.start_pass2 = 1'b1;
				end else begin
					cmd.rd_vis = 1'b1;
				end
			end
			scc_pkg::ST_SCAN1D: begin
				cmd.step_i       = 1'b1;
				cmd.start_search = !sts.seen;
			end
			scc_pkg::ST_FETCH: begin
				cmd.rd_edge = !sts.e_end;
				cmd.pop     = sts.e_end;
			end
			scc_pkg::ST_CHECK: begin
				cmd.vis_src = scc_pkg::VS_EDGE;
				cmd.rd_vis  = sts.match;
				cmd.adv_e   = !sts.match;
			end
			scc_pkg::ST_VCHK: begin
				cmd.vis_src = scc_pkg::VS_EDGE;
				cmd.push    = !sts.seen;
				cmd.adv_e   = sts.seen;
			end
			scc_pkg::ST_POPRD: cmd.load_top = 1'b1;
			scc_pkg::ST_SCAN2: cmd.rd_finish = !sts.k_zero;
			scc_pkg::ST_SCAN2D: begin
				cmd.vis_src = scc_pkg::VS_FIN;
				cmd.rd_vis  = 1'b1;
				cmd.step_k  = 1'b1;
			end
			scc_pkg::ST_SCAN2V: begin
				cmd.vis_src      = scc_pkg::VS_FIN;
				cmd.start_search = !sts.seen;
				cmd.inc_count    = !sts.seen;
			end
			scc_pkg::ST_DONE: cmd.emit = !out_busy;
			default: ;
		endcase
	end

endmodule

`default_nettype wire

// ----- src/scc_dp.sv -----
// ---------------------------------------------------------------------------
// scc_dp
// Edge store, visited marks, finish order, search stack and counters.
// ---------------------------------------------------------------------------
`default_nettype none

module scc_dp #(
	parameter int MAX_NODES = 256,
	parameter int MAX_EDGES = 1024
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  scc_pkg::cmd_t                   cmd,
	output scc_pkg::sts_t                   sts,
	input  wire [scc_pkg::COUNT_W-1:0]      node_count,
	input  wire [scc_pkg::EDGE_NODE_W-1:0]  src_node,
	input  wire [scc_pkg::EDGE_NODE_W-1:0]  dst_node,
	output logic [scc_pkg::COUNT_W-1:0]     count,
	output logic                            dropped
);

	// node_count is 9 bits, so no more than 511 nodes can ever be live
	localparam int NODES = (MAX_NODES > 512) ? 512 : MAX_NODES;
	localparam int VIW   = $clog2(NODES);
	localparam int SPW   = $clog2(NODES + 1);
	localparam int LW    = $clog2(MAX_EDGES + 1);
	localparam int EAW   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int NW    = scc_pkg::NODE_W;
	localparam int EW    = scc_pkg::EDGE_NODE_W;
	localparam logic [scc_pkg::LIVE_W-1:0] NODES_L = scc_pkg::LIVE_W'(NODES);
	localparam logic [scc_pkg::LIVE_W-1:0] CLR_LAST = scc_pkg::LIVE_W'(NODES - 1);
	localparam logic [LW-1:0] EDGES_L = LW'(MAX_EDGES);

	logic [EW-1:0]   tail_mem [MAX_EDGES];
	logic [EW-1:0]   head_mem [MAX_EDGES];
	logic [NW-1:0]   fin_mem  [NODES];
	logic [NW+LW-1:0] stk_mem [NODES];
	logic            vis_mem  [NODES];

	logic [EW-1:0]   tail_rd_q, head_rd_q;
	logic [NW-1:0]   fin_rd_q;
	logic [NW+LW-1:0] stk_rd_q;
	logic            vis_rd_q;

	logic [LW-1:0]   loaded_q;
	logic            drop_q;
	logic [scc_pkg::LIVE_W-1:0] clr_q;
	logic [scc_pkg::LIVE_W-1:0] i_q;
	logic [NW-1:0]   v_q;
	logic [LW-1:0]   e_q;
	logic [SPW-1:0]  sp_q, flen_q, k_q;
	logic            pass_q;
	logic [scc_pkg::COUNT_W-1:0] count_q;

	logic [scc_pkg::LIVE_W-1:0] live_n, ncnt_ext;
	logic [EW-1:0]   from_n, to_n;
	logic [NW-1:0]   vis_idx;
	logic            load_ok;
	logic [SPW-1:0]  sp_m1, sp_m2, k_m1;

	assign ncnt_ext = {1'b0, node_count};
	assign live_n   = (ncnt_ext > NODES_L) ? NODES_L : ncnt_ext;

	// pass one walks the reversed graph
	assign from_n = pass_q ? tail_rd_q : head_rd_q;
	assign to_n   = pass_q ? head_rd_q : tail_rd_q;

	always_comb begin
		case (cmd.vis_src)
			scc_pkg::VS_EDGE: vis_idx = {1'b0, to_n};
			scc_pkg::VS_FIN:  vis_idx = fin_rd_q;
			default:          vis_idx = i_q[NW-1:0];
		endcase
	end

	assign load_ok = (loaded_q < EDGES_L)
		&& (scc_pkg::LIVE_W'(src_node) < live_n)
		&& (scc_pkg::LIVE_W'(dst_node) < live_n);
	assign sp_m1 = sp_q - SPW'(1);
	assign sp_m2 = sp_q - SPW'(2);
	assign k_m1  = k_q - SPW'(1);

	// marks flip polarity per pass: pass one sets them, pass two clears them,
	// so every live mark is back at zero when a run ends
	assign sts.clr_last = (clr_q == CLR_LAST);
	assign sts.i_end    = (i_q == live_n);
	assign sts.e_end    = (e_q == loaded_q);
	assign sts.match    = (NW'(from_n) == v_q) && (scc_pkg::LIVE_W'(to_n) < live_n);
	assign sts.seen     = vis_rd_q ^ pass_q;
	assign sts.sp_one   = (sp_q == SPW'(1));
	assign sts.k_zero   = (k_q == '0);
	assign sts.pass2    = pass_q;

	assign count   = count_q;
	assign dropped = drop_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q <= '0;
			drop_q   <= 1'b0;
			clr_q    <= '0;
			i_q      <= '0;
			v_q      <= '0;
			e_q      <= '0;
			sp_q     <= '0;
			flen_q   <= '0;
			k_q      <= '0;
			pass_q   <= 1'b0;
			count_q  <= '0;
		end else begin
			if (cmd.clr_step) clr_q <= clr_q + scc_pkg::LIVE_W'(1);
			if (cmd.load_edge) begin
				if (load_ok) loaded_q <= loaded_q + LW'(1);
				else drop_q <= 1'b1;
			end
			if (cmd.emit) begin
				loaded_q <= '0;
				drop_q   <= 1'b0;
			end
			if (cmd.start_run) begin
				i_q     <= '0;
				flen_q  <= '0;
				count_q <= '0;
				pass_q  <= 1'b0;
			end
			if (cmd.start_pass2) begin
				k_q    <= flen_q;
				pass_q <= 1'b1;
			end
			if (cmd.step_i) i_q <= i_q + scc_pkg::LIVE_W'(1);
			if (cmd.step_k) k_q <= k_m1;
			if (cmd.inc_count) count_q <= count_q + scc_pkg::COUNT_W'(1);
			if (cmd.start_search) begin
				v_q  <= vis_idx;
				e_q  <= '0;
				sp_q <= SPW'(1);
			end
			if (cmd.adv_e) e_q <= e_q + LW'(1);
			if (cmd.push) begin
				v_q  <= NW'(to_n);
				e_q  <= '0;
				sp_q <= sp_q + SPW'(1);
			end
			if (cmd.pop) begin
				sp_q <= sp_m1;
				if (!pass_q) flen_q <= flen_q + SPW'(1);
			end
			if (cmd.load_top) begin
				v_q <= stk_rd_q[NW+LW-1:LW];
				e_q <= stk_rd_q[LW-1:0];
			end
		end
	end

	// visited marks: cleared once after reset, then one read and one write
	always_ff @(posedge clk) begin
		if (cmd.clr_step) vis_mem[clr_q[VIW-1:0]] <= 1'b0;
		else if (cmd.start_search || cmd.push) vis_mem[vis_idx[VIW-1:0]] <= ~pass_q;
		if (cmd.rd_vis) vis_rd_q <= vis_mem[vis_idx[VIW-1:0]];
	end

	// edge store
	always_ff @(posedge clk) begin
		if (cmd.load_edge && load_ok) begin
			tail_mem[loaded_q[EAW-1:0]] <= src_node;
			head_mem[loaded_q[EAW-1:0]] <= dst_node;
		end
		if (cmd.rd_edge) begin
			tail_rd_q <= tail_mem[e_q[EAW-1:0]];
			head_rd_q <= head_mem[e_q[EAW-1:0]];
		end
	end

	// finish order
	always_ff @(posedge clk) begin
		if (cmd.pop && !pass_q) fin_mem[flen_q[VIW-1:0]] <= v_q;
		if (cmd.rd_finish) fin_rd_q <= fin_mem[k_m1[VIW-1:0]];
	end

	// saved frames below the top of stack; top lives in v_q/e_q
	always_ff @(posedge clk) begin
		if (cmd.push) stk_mem[sp_m1[VIW-1:0]] <= {v_q, e_q + LW'(1)};
		if (cmd.pop) stk_rd_q <= stk_mem[sp_m2[VIW-1:0]];
	end

`ifndef SYNTHESIS
	a_sp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SPW'(NODES))
		else $error("search stack deeper than node capacity");
	a_e_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_edge |-> e_q < loaded_q)
		else $error("edge read past loaded edges");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> sp_q < SPW'(NODES))
		else $error("push onto a full search stack");
`endif

endmodule

`default_nettype wire

// ----- src/scc_counter_core.sv -----
// ---------------------------------------------------------------------------
// scc_counter_core
// Counts strongly connected components of a loaded directed graph
// (Kosaraju: reversed-graph post-order, then forward searches).
// ---------------------------------------------------------------------------
// Usage:
//  - item channel: func 0 adds edge (src_node -> dst_node), one beat per
//    cycle, no result. Bad node or full store drops the edge and sets the
//    dropped flag. func 1 starts a run; no items are taken during a run.
//  - result channel: one beat per run with component_count and
//    edges_dropped; the run then empties the edge store and clears the flag.
//  - APB: register 0 (byte address 0) is node_count; pready is always high.
//  - Run time: with n live nodes and E stored edges, each node scans every
//    edge in each pass, through FETCH and CHECK, and VCHK on a match.
//  - The result sits in an output register; edge loads keep flowing while
//    it waits. A following run finishes and then holds until it is taken.
//  - Reset clears the edge count, flag, node_count and the controller, then
//    a clearing pass zeroes the visited marks (at most 512) while
//    item.ready is low.
// ---------------------------------------------------------------------------
`default_nettype none

module scc_counter_core #(
	parameter int MAX_NODES = 256,
	parameter int MAX_EDGES = 1024
) (
	input  wire                          clk,
	input  wire                          arst_n,
	scc_item_if.sink                     item,
	scc_result_if.source                 result,
	input  wire                          psel,
	input  wire                          penable,
	input  wire                          pwrite,
	input  wire [scc_pkg::APB_AW-1:0]    paddr,
	input  wire [scc_pkg::APB_DW-1:0]    pwdata,
	output logic [scc_pkg::APB_DW-1:0]   prdata,
	output logic                         pready
);

	scc_pkg::cmd_t cmd;
	scc_pkg::sts_t sts;

	logic [scc_pkg::COUNT_W-1:0] node_count_q;
	logic [scc_pkg::COUNT_W-1:0] dp_count;
	logic                        dp_dropped;
	logic                        out_valid_q;
	logic [scc_pkg::COUNT_W-1:0] out_count_q;
	logic                        out_drop_q;
	logic                        out_busy;
	logic                        reg_hit;

	// register index is the word address
	assign reg_hit = (paddr[2] == scc_pkg::REG_NODE_COUNT);
	assign pready  = 1'b1;
	assign prdata  = reg_hit ? scc_pkg::APB_DW'(node_count_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= '0;
		end else if (psel && penable && pwrite && reg_hit) begin
			node_count_q <= pwdata[scc_pkg::COUNT_W-1:0];
		end
	end

	// result register: free when empty or being taken this cycle
	assign out_busy = out_valid_q && !result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_count_q <= dp_count;
			out_drop_q  <= dp_dropped;
		end
	end

	assign result.valid           = out_valid_q;
	assign result.component_count = out_count_q;
	assign result.edges_dropped   = out_drop_q;
	assign item.ready             = cmd.in_ready;

	scc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_func  (item.func),
		.out_busy   (out_busy),
		.sts        (sts),
		.cmd        (cmd)
	);

	scc_dp #(
		.MAX_NODES (MAX_NODES),
		.MAX_EDGES (MAX_EDGES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.node_count (node_count_q),
		.src_node   (item.src_node),
		.dst_node   (item.dst_node),
		.count      (dp_count),
		.dropped    (dp_dropped)
	);

`ifndef SYNTHESIS
	a_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready && item.func |=> !item.ready)
		else $error("item taken right after run start");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> dp_count <= node_count_q)
		else $error("component count above node count");
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !out_busy)
		else $error("result overwritten before taken");
`endif

endmodule

`default_nettype wire
